// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the gradient pixel RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define GDP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gradient pixel: implication failed");

// next-cycle implication, off while reset is high
`define GDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gradient pixel: next-cycle check failed");

// state right after a reset cycle
`define GDP_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("gradient pixel: reset check failed");

`endif

// ===== hw/rtl/gdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gdp_pkg
// Widths, pipeline layout, register codes and the Bayer table.
// ----------------------------------------------------------------------------
package gdp_pkg;

   localparam int CHAN_W   = 16;
   localparam int NUM_CHAN = 4;
   localparam int COORD_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 13;

   // |end-start| * pos, and the quotient kept up to the point where it saturates
   localparam int PROD_W = CHAN_W + COORD_W;
   localparam int QUO_W  = CHAN_W + 1;
   localparam int HEAD_W = PROD_W - QUO_W;
   localparam int SUM_W  = QUO_W + 2;

   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam int ST_FRONT    = 0;
   localparam int ST_MUL      = 1;
   localparam int ST_DIV0     = 2;
   localparam int ST_OUT      = ST_DIV0 + DIV_STAGES;
   localparam int PIPE_STAGES = ST_OUT + 1;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 16'hFF00;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_COLOR = 2'd0,
      CSR_END_COLOR   = 2'd1,
      CSR_VERTICAL    = 2'd2,
      CSR_LENGTH      = 2'd3
   } csr_index_type;

   localparam int DITHER_DIM = 8;
   localparam int BAYER_W    = 6;

   typedef logic [BAYER_W-1:0] bayer_type;

   localparam bayer_type BAYER_TAB [DITHER_DIM*DITHER_DIM] = '{
      6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
      6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
      6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
      6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
      6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
      6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
      6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
      6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
   };

   typedef struct packed {
      logic [NUM_CHAN*CHAN_W-1:0] start_color;
      logic [NUM_CHAN*CHAN_W-1:0] end_color;
      logic                       vertical;
      logic                       flat;
   } cfg_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
      logic [PIPE_STAGES-1:0] valid;
   } pipe_ctl_type;

endpackage

// ===== hw/rtl/gdp_if.sv =====
// ----------------------------------------------------------------------------
// gdp_if
// Valid/ready channels: pixel request, RGBA response, register write.
// ----------------------------------------------------------------------------
interface gdp_req_if;
   logic                         valid;
   logic                         ready;
   logic [gdp_pkg::COORD_W-1:0]  pixel_x;
   logic [gdp_pkg::COORD_W-1:0]  pixel_y;

   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface gdp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gdp_pkg::BYTE_W-1:0]   red;
   logic [gdp_pkg::BYTE_W-1:0]   green;
   logic [gdp_pkg::BYTE_W-1:0]   blue;
   logic [gdp_pkg::BYTE_W-1:0]   alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface gdp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gdp_pkg::CSR_IDX_W-1:0]   index;
   logic [gdp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gdp_csr.sv =====
// ----------------------------------------------------------------------------
// gdp_csr
// Configuration registers and the divisor derived from the gradient length.
// ----------------------------------------------------------------------------
module gdp_csr #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   gdp_csr_if.sink                       csr_if,
   output gdp_pkg::cfg_type              cfg,
   output logic [$clog2(MAX_LENGTH)-1:0] divisor
);

   localparam int DIV_W   = $clog2(MAX_LENGTH);
   localparam int MAXL_W  = $clog2(MAX_LENGTH + 1);
   localparam int SAT_W   = (gdp_pkg::LEN_W > MAXL_W) ? gdp_pkg::LEN_W : MAXL_W;
   localparam int COLOR_W = gdp_pkg::NUM_CHAN * gdp_pkg::CHAN_W;

   logic [COLOR_W-1:0]        start_ff, start_in;
   logic [COLOR_W-1:0]        end_ff, end_in;
   logic                      vert_ff, vert_in;
   logic [gdp_pkg::LEN_W-1:0] len_ff, len_in;
   logic                      flat_ff, flat_in;
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [SAT_W-1:0]          len_wide, len_sat;

   assign csr_if.ready = 1'b1;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      vert_in  = vert_ff;
      len_in   = len_ff;
      if (csr_if.valid) begin
         unique case (gdp_pkg::csr_index_type'(csr_if.index))
            gdp_pkg::CSR_START_COLOR: start_in = csr_if.data[COLOR_W-1:0];
            gdp_pkg::CSR_END_COLOR:   end_in   = csr_if.data[COLOR_W-1:0];
            gdp_pkg::CSR_VERTICAL:    vert_in  = csr_if.data[0];
            gdp_pkg::CSR_LENGTH:      len_in   = csr_if.data[gdp_pkg::LEN_W-1:0];
            default:                  len_in   = len_ff;
         endcase
      end
   end

   // saturate the length, then take length-1 as the divisor; a flat gradient keeps a dummy 1
   always_comb begin
      len_wide = SAT_W'(len_in);
      len_sat  = (len_wide > SAT_W'(MAX_LENGTH)) ? SAT_W'(MAX_LENGTH) : len_wide;
      flat_in  = (len_in <= gdp_pkg::LEN_W'(1));
      div_in   = flat_in ? DIV_W'(1) : DIV_W'(len_sat - SAT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         vert_ff  <= 1'b1;
         len_ff   <= gdp_pkg::LEN_W'(1);
         flat_ff  <= 1'b1;
         div_ff   <= DIV_W'(1);
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         vert_ff  <= vert_in;
         len_ff   <= len_in;
         flat_ff  <= flat_in;
         div_ff   <= div_in;
      end
   end

   assign cfg.start_color = start_ff;
   assign cfg.end_color   = end_ff;
   assign cfg.vertical    = vert_ff;
   assign cfg.flat        = flat_ff;
   assign divisor         = div_ff;

endmodule

// ===== hw/rtl/gdp_pipe.sv =====
// ----------------------------------------------------------------------------
// gdp_pipe
// Valid bits and per-stage load enables of the pixel pipeline.
// ----------------------------------------------------------------------------
module gdp_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output gdp_pkg::pipe_ctl_type ctl
);

   localparam int N = gdp_pkg::PIPE_STAGES;

   logic [N-1:0] vld_ff, vld_in;
   logic [N-1:0] adv;

   // a stage takes a new beat when it is empty or its beat moves on
   always_comb begin
      adv[N-1] = !vld_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < N; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load  = adv;
   assign ctl.valid = vld_ff;

endmodule

// ===== hw/rtl/gdp_lane.sv =====
// ----------------------------------------------------------------------------
// gdp_lane
// One colour channel: difference, multiply, pipelined divide, clamp, dither.
// ----------------------------------------------------------------------------
module gdp_lane #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic                          clock,
   input  gdp_pkg::pipe_ctl_type         ctl,
   input  logic [gdp_pkg::CHAN_W-1:0]    start_chan,
   input  logic [gdp_pkg::CHAN_W-1:0]    end_chan,
   input  logic                          flat,
   input  logic [gdp_pkg::COORD_W-1:0]   pos,
   input  logic [$clog2(MAX_LENGTH)-1:0] divisor,
   input  logic [gdp_pkg::BYTE_W-1:0]    thr,
   output logic [gdp_pkg::BYTE_W-1:0]    byte_ff
);

   localparam int DIV_W  = $clog2(MAX_LENGTH);
   localparam int CW     = gdp_pkg::CHAN_W;
   localparam int QW     = gdp_pkg::QUO_W;
   localparam int PW     = gdp_pkg::PROD_W;
   localparam int HW     = gdp_pkg::HEAD_W;
   localparam int CMP_W  = (DIV_W > HW) ? DIV_W : HW;
   localparam int NDIV   = gdp_pkg::DIV_STAGES;
   localparam int NCARRY = gdp_pkg::ST_OUT;

   logic [CW-1:0]    s_ff   [NCARRY];
   logic             neg_ff [NCARRY];
   logic [CW-1:0]    dmag_ff, dmag_in;
   logic             neg_in;
   logic [CW:0]      diff;
   logic [PW-1:0]    prod_ff;
   logic [DIV_W-1:0] rem_ff [NDIV];
   logic [QW-1:0]    nq_ff  [NDIV];
   logic             sat_ff [NDIV];
   logic [CW-1:0]    val;
   logic [gdp_pkg::SUM_W-1:0] sum, addend;
   logic [gdp_pkg::BYTE_W-1:0] byte_in;

   // front: sign and magnitude of end-start; a flat gradient contributes nothing
   always_comb begin
      diff    = {1'b0, end_chan} - {1'b0, start_chan};
      neg_in  = diff[CW] && !flat;
      dmag_in = flat ? '0 : (diff[CW] ? CW'(-diff) : diff[CW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[gdp_pkg::ST_FRONT]) begin
         s_ff[0]   <= start_chan;
         neg_ff[0] <= neg_in;
         dmag_ff   <= dmag_in;
      end
      for (int i = 1; i < NCARRY; i++) begin
         if (ctl.load[i]) begin
            s_ff[i]   <= s_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
      if (ctl.load[gdp_pkg::ST_MUL]) begin
         prod_ff <= {{gdp_pkg::COORD_W{1'b0}}, dmag_ff} * {{CW{1'b0}}, pos};
      end
   end

   // restoring division, a few quotient bits per stage; the first stage also
   // flags quotients too large to matter, which saturate the channel
   for (genvar j = 0; j < NDIV; j++) begin : g_div
      logic [DIV_W-1:0] rem_src, rem_in;
      logic [QW-1:0]    nq_src, nq_in;
      logic             sat_src;
      logic [DIV_W:0]   trial;

      if (j == 0) begin : g_head
         assign sat_src = (CMP_W'(prod_ff[PW-1:QW]) >= CMP_W'(divisor));
         assign rem_src = sat_src ? '0 : DIV_W'(prod_ff[PW-1:QW]);
         assign nq_src  = prod_ff[QW-1:0];
      end else begin : g_body
         assign sat_src = sat_ff[j-1];
         assign rem_src = rem_ff[j-1];
         assign nq_src  = nq_ff[j-1];
      end

      always_comb begin
         rem_in = rem_src;
         nq_in  = nq_src;
         trial  = '0;
         for (int k = 0; k < gdp_pkg::DIV_STEPS; k++) begin
            if (j * gdp_pkg::DIV_STEPS + k < QW) begin
               trial = {rem_in, nq_in[QW-1]};
               nq_in = {nq_in[QW-2:0], 1'b0};
               if (trial >= {1'b0, divisor}) begin
                  trial    = trial - {1'b0, divisor};
                  nq_in[0] = 1'b1;
               end
               rem_in = trial[DIV_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.load[gdp_pkg::ST_DIV0 + j]) begin
            rem_ff[j] <= rem_in;
            nq_ff[j]  <= nq_in;
            sat_ff[j] <= sat_src;
         end
      end
   end

   // output: apply the sign, clamp to [0, 255.0], round up against the threshold
   always_comb begin
      addend = {2'b00, nq_ff[NDIV-1]};
      if (neg_ff[NCARRY-1]) begin
         addend = ~addend + gdp_pkg::SUM_W'(1);
      end
      sum = {3'b000, s_ff[NCARRY-1]} + addend;
      priority if (sat_ff[NDIV-1]) begin
         val = neg_ff[NCARRY-1] ? '0 : gdp_pkg::CHAN_MAX;
      end else if (sum[gdp_pkg::SUM_W-1]) begin
         val = '0;
      end else if (sum[gdp_pkg::SUM_W-2:0] > (gdp_pkg::SUM_W-1)'(gdp_pkg::CHAN_MAX)) begin
         val = gdp_pkg::CHAN_MAX;
      end else begin
         val = sum[CW-1:0];
      end
      byte_in = val[CW-1:gdp_pkg::BYTE_W];
      if (val[CW-1:gdp_pkg::BYTE_W] != {gdp_pkg::BYTE_W{1'b1}}
          && val[gdp_pkg::BYTE_W-1:0] > thr) begin
         byte_in = val[CW-1:gdp_pkg::BYTE_W] + gdp_pkg::BYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[gdp_pkg::ST_OUT]) begin
         byte_ff <= byte_in;
      end
   end

endmodule

// ===== hw/rtl/dithered_gradient_pixel.sv =====
// ----------------------------------------------------------------------------
// dithered_gradient_pixel
// Two-colour linear gradient pixel source with 8x8 ordered dithering.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one beat per pixel, carrying pixel_x and pixel_y.
//   rsp_if  : one beat per request, in order, with the red, green, blue and
//             alpha bytes of that pixel.
//   csr_if  : register writes (start colour, end colour, direction, length),
//             always ready; write only while no request is in flight.
//   Throughput is one pixel per clock while the receiver keeps up. A request
//   passes nine register stages before its result is offered on rsp_if:
//   front end, multiply, six stages of a three-bits-per-stage divider by
//   length-1, then clamp and dither into the output register.
//   When the receiver holds off, the output register keeps its beat and
//   bubbles in the pipeline fill up first; req_if.ready drops only once
//   every stage holds a beat. Nothing is dropped or repeated.
//   Reset empties the pipeline and loads start = end = 0, vertical
//   direction and a length of 1 (every pixel takes the start colour).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dithered_gradient_pixel #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic       clock,
   input  logic       reset,
   gdp_req_if.sink    req_if,
   gdp_rsp_if.source  rsp_if,
   gdp_csr_if.sink    csr_if
);

   localparam int DIV_W = $clog2(MAX_LENGTH);
   localparam int NTHR  = gdp_pkg::ST_OUT;

   gdp_pkg::cfg_type       cfg;
   gdp_pkg::pipe_ctl_type  pipe_ctl;
   logic [DIV_W-1:0]       divisor;

   logic [gdp_pkg::COORD_W-1:0] pos_ff, pos_in;
   logic [gdp_pkg::BYTE_W-1:0]  thr_ff [NTHR];
   logic [gdp_pkg::BYTE_W-1:0]  thr_in;
   logic [gdp_pkg::BYTE_W-1:0]  chan_byte [gdp_pkg::NUM_CHAN];

   gdp_csr #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_if  (csr_if),
      .cfg     (cfg),
      .divisor (divisor)
   );

   gdp_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .ctl       (pipe_ctl)
   );

   // position along the gradient and the dither threshold 4*bayer+2
   always_comb begin
      pos_in = cfg.vertical ? req_if.pixel_y : req_if.pixel_x;
      thr_in = {gdp_pkg::BAYER_TAB[{req_if.pixel_y[2:0], req_if.pixel_x[2:0]}], 2'b10};
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.load[gdp_pkg::ST_FRONT]) begin
         pos_ff    <= pos_in;
         thr_ff[0] <= thr_in;
      end
      for (int i = 1; i < NTHR; i++) begin
         if (pipe_ctl.load[i]) begin
            thr_ff[i] <= thr_ff[i-1];
         end
      end
   end

   for (genvar c = 0; c < gdp_pkg::NUM_CHAN; c++) begin : g_lane
      gdp_lane #(
         .MAX_LENGTH (MAX_LENGTH)
      ) u_lane (
         .clock      (clock),
         .ctl        (pipe_ctl),
         .start_chan (cfg.start_color[c*gdp_pkg::CHAN_W +: gdp_pkg::CHAN_W]),
         .end_chan   (cfg.end_color[c*gdp_pkg::CHAN_W +: gdp_pkg::CHAN_W]),
         .flat       (cfg.flat),
         .pos        (pos_ff),
         .divisor    (divisor),
         .thr        (thr_ff[NTHR-1]),
         .byte_ff    (chan_byte[c])
      );
   end

   assign req_if.ready = pipe_ctl.load[gdp_pkg::ST_FRONT];
   assign rsp_if.valid = pipe_ctl.valid[gdp_pkg::ST_OUT];
   assign rsp_if.red   = chan_byte[0];
   assign rsp_if.green = chan_byte[1];
   assign rsp_if.blue  = chan_byte[2];
   assign rsp_if.alpha = chan_byte[3];

   `GDP_ASSERT_RESET(a_reset_empties, clock, reset, !rsp_if.valid)
   `GDP_ASSERT_IMPL(a_flow_through, clock, reset, rsp_if.ready, req_if.ready)
   `GDP_ASSERT_NEXT(a_beat_enters, clock, reset, req_if.valid && req_if.ready, pipe_ctl.valid[gdp_pkg::ST_FRONT])

endmodule
